// File: rtl/blg_pkg.sv
// Package for the battery level gauge: payload structs, field widths,
// register indexes, reset values and status codes. No dependencies.
package blg_pkg;

    localparam int MV_W      = 14;                  // millivolt fields and registers
    localparam int PCT_W     = 7;                   // unsigned percentage 0..100
    localparam int LVL_W     = 8;                   // signed level, -1 when unknown
    localparam int RAMP_W    = 8;
    localparam int STAT_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 14;

    localparam int PCT_FULL  = 100;
    // (mv - empty) * 100 stays below span * 2^7 when mv < full, so 7 quotient bits do
    localparam int DIV_STEPS = PCT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int DVD_W     = MV_W + DIV_STEPS;

    localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FULL_MV     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ABSENT_MV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAMP_POLLS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_USB_PRES_MV = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_USB_OFFS_MV = 3'd5;

    localparam logic [MV_W-1:0]   RST_EMPTY_MV    = 14'd3270;
    localparam logic [MV_W-1:0]   RST_FULL_MV     = 14'd4200;
    localparam logic [MV_W-1:0]   RST_ABSENT_MV   = 14'd3000;
    localparam logic [RAMP_W-1:0] RST_RAMP_POLLS  = 8'd5;
    localparam logic [MV_W-1:0]   RST_USB_PRES_MV = 14'd4000;
    localparam logic [MV_W-1:0]   RST_USB_OFFS_MV = 14'd400;

    localparam logic [STAT_W-1:0] ST_UNKNOWN     = 3'd0;
    localparam logic [STAT_W-1:0] ST_NO_BATTERY  = 3'd1;
    localparam logic [STAT_W-1:0] ST_CHARGING    = 3'd2;
    localparam logic [STAT_W-1:0] ST_CHARGED     = 3'd3;
    localparam logic [STAT_W-1:0] ST_DISCHARGING = 3'd4;

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_POLL = 1'b1;

    localparam logic signed [LVL_W-1:0] LEVEL_NONE = -8'sd1;

    typedef struct packed {
        logic            cmd;
        logic [MV_W-1:0] batt_mv;
        logic [MV_W-1:0] bus_mv;
        logic            pmu_ready;
        logic            batt_present;
        logic            charging;
        logic            charge_done;
    } t_blg_in;

    typedef struct packed {
        logic signed [LVL_W-1:0] level_pct;
        logic [STAT_W-1:0]       status;
        logic [MV_W-1:0]         volts_out;
    } t_blg_out;

endpackage

// File: rtl/battery_level_gauge_rate_limited.sv
// Battery level gauge: voltage to percent mapping with seed, poll and upward slew limit.
// Depends on blg_pkg and on the divider blg_div.
// The result is registered through the prep and post states when no division is needed
// (level clamped to 0 or 100), and through prep, the 7-step serial divider and post otherwise.
// The post state waits for a free output; no new item is accepted until post is done.
// Reset (synchronous, active low): registers to defaults, no level stored, ramp count zero.
module battery_level_gauge_rate_limited
    import blg_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_blg_in              i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_blg_out             o_out_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PREP = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_POST = 2'd3;

    logic [1:0]              r_state, n_state;
    t_blg_in                 r_item, n_item;
    logic                    r_mapok, n_mapok;
    logic [PCT_W-1:0]        r_map, n_map;
    logic signed [LVL_W-1:0] r_last, n_last;
    logic [RAMP_W-1:0]       r_ramp, n_ramp;
    logic                    r_out_valid, n_out_valid;
    t_blg_out                r_out, n_out;

    logic [MV_W-1:0]         r_empty_mv, r_full_mv, r_absent_mv;
    logic [MV_W-1:0]         r_usb_pres_mv, r_usb_offs_mv;
    logic [RAMP_W-1:0]       r_ramp_polls;

    logic [MV_W-1:0]         w_mv;
    logic [MV_W-1:0]         w_span_diff;
    logic [DVD_W-1:0]        w_dividend;
    logic [MV_W-1:0]         w_span;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [PCT_W-1:0]        w_quotient;
    logic [STAT_W-1:0]       w_status;
    logic                    w_out_free;
    logic [RAMP_W-1:0]       w_ramp_inc;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_empty_mv    <= RST_EMPTY_MV;
            r_full_mv     <= RST_FULL_MV;
            r_absent_mv   <= RST_ABSENT_MV;
            r_ramp_polls  <= RST_RAMP_POLLS;
            r_usb_pres_mv <= RST_USB_PRES_MV;
            r_usb_offs_mv <= RST_USB_OFFS_MV;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_EMPTY_MV:    r_empty_mv    <= i_cfg_data[MV_W-1:0];
                REG_FULL_MV:     r_full_mv     <= i_cfg_data[MV_W-1:0];
                REG_ABSENT_MV:   r_absent_mv   <= i_cfg_data[MV_W-1:0];
                REG_RAMP_POLLS:  r_ramp_polls  <= i_cfg_data[RAMP_W-1:0];
                REG_USB_PRES_MV: r_usb_pres_mv <= i_cfg_data[MV_W-1:0];
                REG_USB_OFFS_MV: r_usb_offs_mv <= i_cfg_data[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // seed lowers the voltage by the offset when USB power shows
    always_comb begin
        w_mv = r_item.batt_mv;
        if (r_item.cmd == CMD_SEED && r_item.bus_mv > r_usb_pres_mv &&
            r_item.batt_mv > r_usb_offs_mv) begin
            w_mv = r_item.batt_mv - r_usb_offs_mv;
        end
    end

    always_comb begin
        if (!r_item.pmu_ready) begin
            w_status = ST_UNKNOWN;
        end else if (!r_item.batt_present || r_item.batt_mv < r_absent_mv) begin
            w_status = ST_NO_BATTERY;
        end else if (r_item.charging) begin
            w_status = ST_CHARGING;
        end else if (r_item.charge_done) begin
            w_status = ST_CHARGED;
        end else begin
            w_status = ST_DISCHARGING;
        end
    end

    assign w_span_diff = w_mv - r_empty_mv;
    assign w_span      = r_full_mv - r_empty_mv;
    assign w_dividend  = DVD_W'(w_span_diff) * DVD_W'(PCT_FULL);
    assign w_out_free  = !r_out_valid || i_out_ready;
    assign w_ramp_inc  = r_ramp + 1'b1;

    blg_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_span),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_mapok     = r_mapok;
        n_map       = r_map;
        n_last      = r_last;
        n_ramp      = r_ramp;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_div_start = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_item  = i_in_data;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_item.cmd == CMD_SEED) begin
                    n_mapok = r_item.pmu_ready && (w_mv >= r_absent_mv);
                end else begin
                    n_mapok = r_item.pmu_ready && r_item.batt_present &&
                              (r_item.batt_mv != '0);
                end
                n_state = S_POST;
                if (w_mv >= r_full_mv) begin
                    n_map = PCT_W'(PCT_FULL);
                end else if (r_full_mv <= r_empty_mv || w_mv <= r_empty_mv) begin
                    n_map = '0;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_map   = w_quotient;
                    n_state = S_POST;
                end
            end
            S_POST: begin
                if (w_out_free) begin
                    n_out.status    = w_status;
                    n_out.volts_out = (r_item.pmu_ready && r_item.batt_present) ?
                                      r_item.batt_mv : '0;
                    if (r_item.cmd == CMD_SEED) begin
                        if (r_mapok) begin
                            n_last = LVL_W'(r_map);
                        end
                        n_out.level_pct = r_mapok ? LVL_W'(r_map) : r_last;
                    end else if (!r_mapok) begin
                        n_out.level_pct = LEVEL_NONE;
                    end else begin
                        n_out.level_pct = LVL_W'(r_map);
                        if (!r_last[LVL_W-1] && r_map > r_last[PCT_W-1:0]) begin
                            // upward move: hold, or step by one once the ramp count is met
                            n_out.level_pct = r_last;
                            if (r_item.charging) begin
                                n_ramp = w_ramp_inc;
                                if (w_ramp_inc >= r_ramp_polls) begin
                                    n_ramp          = '0;
                                    n_out.level_pct = r_last + LVL_W'(1);
                                end
                            end
                        end else begin
                            n_ramp = '0;
                        end
                        n_last = n_out.level_pct;
                    end
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= LEVEL_NONE;
            r_ramp      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_last      <= n_last;
            r_ramp      <= n_ramp;
            r_out_valid <= n_out_valid;
        end
        r_item  <= n_item;
        r_mapok <= n_mapok;
        r_map   <= n_map;
        r_out   <= n_out;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_level_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.level_pct >= LEVEL_NONE &&
                         o_out_data.level_pct <= LVL_W'(PCT_FULL)))
        else $error("level out of range");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while busy");

    a_unknown_volts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_UNKNOWN) |-> (o_out_data.volts_out == '0))
        else $error("voltage reported while chip not ready");

endmodule

// File: rtl/blg_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on blg_pkg for the widths and the step count.
module blg_div
    import blg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DVD_W-1:0]  i_dividend,
    input  logic [MV_W-1:0]   i_divisor,
    output logic              o_done,
    output logic [PCT_W-1:0]  o_quotient
);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [MV_W-1:0]      r_rem, n_rem;
    logic [PCT_W-1:0]     r_quo, n_quo;
    logic [MV_W-1:0]      r_dvs, n_dvs;

    logic [MV_W:0]        w_trial;
    logic [MV_W:0]        w_diff;
    logic                 w_ge;

    assign w_trial = {r_rem, r_quo[PCT_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = i_dividend[DVD_W-1:PCT_W];
            n_quo  = i_dividend[PCT_W-1:0];
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so it fits MV_W bits
            n_rem = w_ge ? w_diff[MV_W-1:0] : w_trial[MV_W-1:0];
            n_quo = {r_quo[PCT_W-2:0], w_ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
